// ===== rtl/cit_pkg.sv =====
// ----------------------------------------------------------------------------
// cit_pkg: shared constants for the cube interior ambiguity test
// Sample width, widths of the intermediate terms, and the register map.
// ----------------------------------------------------------------------------
package cit_pkg;

	localparam int SAMPLE_W = 16;

	// Corner differences and the products built from them.
	localparam int D_W = SAMPLE_W + 1;
	localparam int P_W = 2 * SAMPLE_W + 2;
	localparam int T_W = 2 * SAMPLE_W + 1;
	localparam int Q_W = 2 * SAMPLE_W;

	// Quadratic coefficients a, b, c and the slope check b + 2a.
	localparam int A_W = 2 * SAMPLE_W + 3;
	localparam int B_W = 2 * SAMPLE_W + 3;
	localparam int C_W = 2 * SAMPLE_W + 1;
	localparam int E_W = A_W + 2;

	// Magnitudes split into two halves for the discriminant products.
	localparam int M_W   = 2 * SAMPLE_W + 2;
	localparam int H_W   = SAMPLE_W + 1;
	localparam int PP_W  = 2 * H_W;
	localparam int SQ_W  = 2 * M_W;
	localparam int CMP_W = 2 * M_W + 2;

	// Result and register map.
	localparam int IDX_W   = 8;
	localparam int TB_W    = 4;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [TB_W-1:0] TB_RESET = TB_W'(1);
	localparam logic [TB_W-1:0] TB_MIN   = TB_W'(1);
	localparam logic [TB_W-1:0] TB_MAX   = TB_W'(IDX_W);

	localparam logic REG_TEST_BIT = 1'b0;

endpackage

// ===== rtl/cit_if.sv =====
// ----------------------------------------------------------------------------
// cit_if: stream channels of the cube interior ambiguity test
// One channel carries cube corner samples in, the other carries results out.
// ----------------------------------------------------------------------------
interface cit_cube_if;

	logic                                valid;
	logic                                ready;
	logic signed [cit_pkg::SAMPLE_W-1:0] corner_0;
	logic signed [cit_pkg::SAMPLE_W-1:0] corner_1;
	logic signed [cit_pkg::SAMPLE_W-1:0] corner_2;
	logic signed [cit_pkg::SAMPLE_W-1:0] corner_3;
	logic signed [cit_pkg::SAMPLE_W-1:0] corner_4;
	logic signed [cit_pkg::SAMPLE_W-1:0] corner_5;
	logic signed [cit_pkg::SAMPLE_W-1:0] corner_6;
	logic signed [cit_pkg::SAMPLE_W-1:0] corner_7;
	logic                                face_positive;
	logic                                last_cube;

	modport source (
		output valid, corner_0, corner_1, corner_2, corner_3,
		output corner_4, corner_5, corner_6, corner_7, face_positive, last_cube,
		input  ready
	);

	modport sink (
		input  valid, corner_0, corner_1, corner_2, corner_3,
		input  corner_4, corner_5, corner_6, corner_7, face_positive, last_cube,
		output ready
	);

endinterface

interface cit_result_if;

	logic                             valid;
	logic                             ready;
	logic [cit_pkg::IDX_W-1:0]        index_bits;
	logic                             last_result;

	modport source (
		output valid, index_bits, last_result,
		input  ready
	);

	modport sink (
		input  valid, index_bits, last_result,
		output ready
	);

endinterface

// ===== rtl/cit_cfg.sv =====
// ----------------------------------------------------------------------------
// cit_cfg: configuration register file
// Holds test_bit, written and read over the APB-style port.
// ----------------------------------------------------------------------------
module cit_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cit_pkg::PADDR_W-1:0]   paddr,
	input  logic [cit_pkg::PDATA_W-1:0]   pwdata,
	output logic [cit_pkg::PDATA_W-1:0]   prdata,
	output logic [cit_pkg::TB_W-1:0]      test_bit
);

	logic [cit_pkg::TB_W-1:0] test_bit_q;
	logic                     wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_bit_q <= cit_pkg::TB_RESET;
		end else if (wr_en && (paddr[2] == cit_pkg::REG_TEST_BIT)) begin
			test_bit_q <= pwdata[cit_pkg::TB_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			cit_pkg::REG_TEST_BIT: begin
				prdata = cit_pkg::PDATA_W'(test_bit_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign test_bit = test_bit_q;

endmodule

// ===== rtl/cube_interior_ambiguity_test.sv =====
// ----------------------------------------------------------------------------
// cube_interior_ambiguity_test: marching-cubes interior ambiguity test
// Forms the face coefficients a, b, c from eight corner samples, tests the
// interior parabola exactly in integers, and applies the face sign.
//
//   channel   | dir | beat contents
//   ----------+-----+-----------------------------------------------------
//   cube      | in  | corner_0..corner_7, face_positive, last_cube
//   result    | out | index_bits, last_result
//   APB port  | in  | test_bit at byte address 0
//
// A cube is accepted every cycle while the result channel does not stall the pipeline.
// The seven stages are subtract, multiply, sum, sign checks and magnitudes,
// half-width partial products, product sums, and the final compare.
// Each stage holds when it is full and the stage after it cannot take its beat,
// so bubbles close up and a stalled result loses or repeats nothing.
// Reset clears all valid bits and sets test_bit to one.
// ----------------------------------------------------------------------------
module cube_interior_ambiguity_test (
	input  logic                          clk,
	input  logic                          arst_n,
	cit_cube_if.sink                      cube,
	cit_result_if.source                  result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cit_pkg::PADDR_W-1:0]   paddr,
	input  logic [cit_pkg::PDATA_W-1:0]   pwdata,
	output logic [cit_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int SAMPLE_W = cit_pkg::SAMPLE_W;
	localparam int D_W      = cit_pkg::D_W;
	localparam int P_W      = cit_pkg::P_W;
	localparam int T_W      = cit_pkg::T_W;
	localparam int Q_W      = cit_pkg::Q_W;
	localparam int A_W      = cit_pkg::A_W;
	localparam int B_W      = cit_pkg::B_W;
	localparam int C_W      = cit_pkg::C_W;
	localparam int E_W      = cit_pkg::E_W;
	localparam int M_W      = cit_pkg::M_W;
	localparam int H_W      = cit_pkg::H_W;
	localparam int PP_W     = cit_pkg::PP_W;
	localparam int SQ_W     = cit_pkg::SQ_W;
	localparam int CMP_W    = cit_pkg::CMP_W;
	localparam int IDX_W    = cit_pkg::IDX_W;
	localparam int TB_W     = cit_pkg::TB_W;
	localparam int SH_W     = $clog2(IDX_W);

	logic [TB_W-1:0] test_bit;

	cit_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.test_bit (test_bit)
	);

	assign pready = 1'b1;

	// Valid bits and stage enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v_s7 || result.ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign cube.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= cube.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// Stage 1: corner differences.
	logic signed [D_W-1:0]      da_s1, db_s1, dc_s1, dd_s1;
	logic signed [SAMPLE_W-1:0] a0_s1, b0_s1, c0_s1, d0_s1;
	logic                       face_s1, last_s1;

	always_ff @(posedge clk) begin
		if (en1 && cube.valid) begin
			da_s1   <= D_W'(cube.corner_4) - D_W'(cube.corner_0);
			db_s1   <= D_W'(cube.corner_7) - D_W'(cube.corner_3);
			dc_s1   <= D_W'(cube.corner_6) - D_W'(cube.corner_2);
			dd_s1   <= D_W'(cube.corner_5) - D_W'(cube.corner_1);
			a0_s1   <= cube.corner_0;
			d0_s1   <= cube.corner_1;
			c0_s1   <= cube.corner_2;
			b0_s1   <= cube.corner_3;
			face_s1 <= cube.face_positive;
			last_s1 <= cube.last_cube;
		end
	end

	// Stage 2: products.
	logic signed [P_W-1:0] pac_s2, pbd_s2;
	logic signed [T_W-1:0] tca_s2, tad_s2, tdb_s2, tbd_s2;
	logic signed [Q_W-1:0] qac_s2, qbd_s2;
	logic                  face_s2, last_s2;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			pac_s2  <= da_s1 * dc_s1;
			pbd_s2  <= db_s1 * dd_s1;
			tca_s2  <= c0_s1 * da_s1;
			tad_s2  <= a0_s1 * dc_s1;
			tdb_s2  <= d0_s1 * db_s1;
			tbd_s2  <= b0_s1 * dd_s1;
			qac_s2  <= a0_s1 * c0_s1;
			qbd_s2  <= b0_s1 * d0_s1;
			face_s2 <= face_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: coefficients a, b, c.
	logic signed [A_W-1:0] a_s3;
	logic signed [B_W-1:0] b_s3;
	logic signed [C_W-1:0] c_s3;
	logic                  face_s3, last_s3;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			a_s3    <= A_W'(pac_s2) - A_W'(pbd_s2);
			b_s3    <= B_W'(tca_s2) + B_W'(tad_s2) - B_W'(tdb_s2) - B_W'(tbd_s2);
			c_s3    <= C_W'(qac_s2) - C_W'(qbd_s2);
			face_s3 <= face_s2;
			last_s3 <= last_s2;
		end
	end

	// Stage 4: sign checks and magnitudes.
	logic signed [E_W-1:0] slope_w;
	logic signed [A_W-1:0] nega_w;
	logic signed [C_W-1:0] negc_w;

	assign slope_w = E_W'(b_s3) + (E_W'(a_s3) <<< 1);
	assign nega_w  = -a_s3;
	assign negc_w  = -c_s3;

	logic           pre_s4, cneg_s4, face_s4, last_s4;
	logic [M_W-1:0] mag_a_s4, mag_b_s4, mag_c_s4;

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			pre_s4   <= a_s3[A_W-1] && !b_s3[B_W-1] && (b_s3 != '0) && slope_w[E_W-1];
			cneg_s4  <= c_s3[C_W-1];
			mag_a_s4 <= nega_w[M_W-1:0];
			mag_b_s4 <= b_s3[M_W-1:0];
			mag_c_s4 <= M_W'($unsigned(negc_w));
			face_s4  <= face_s3;
			last_s4  <= last_s3;
		end
	end

	// Stage 5: half-width partial products of b*b and |a|*|c|.
	logic [PP_W-1:0] bb_hh_s5, bb_hl_s5, bb_ll_s5;
	logic [PP_W-1:0] ac_hh_s5, ac_hl_s5, ac_lh_s5, ac_ll_s5;
	logic            pre_s5, cneg_s5, face_s5, last_s5;

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			bb_hh_s5 <= mag_b_s4[M_W-1:H_W] * mag_b_s4[M_W-1:H_W];
			bb_hl_s5 <= mag_b_s4[M_W-1:H_W] * mag_b_s4[H_W-1:0];
			bb_ll_s5 <= mag_b_s4[H_W-1:0] * mag_b_s4[H_W-1:0];
			ac_hh_s5 <= mag_a_s4[M_W-1:H_W] * mag_c_s4[M_W-1:H_W];
			ac_hl_s5 <= mag_a_s4[M_W-1:H_W] * mag_c_s4[H_W-1:0];
			ac_lh_s5 <= mag_a_s4[H_W-1:0] * mag_c_s4[M_W-1:H_W];
			ac_ll_s5 <= mag_a_s4[H_W-1:0] * mag_c_s4[H_W-1:0];
			pre_s5   <= pre_s4;
			cneg_s5  <= cneg_s4;
			face_s5  <= face_s4;
			last_s5  <= last_s4;
		end
	end

	// Stage 6: full products.
	logic [SQ_W-1:0] sq_s6, ac_s6;
	logic            pre_s6, cneg_s6, face_s6, last_s6;

	always_ff @(posedge clk) begin
		if (en6 && v_s5) begin
			sq_s6   <= (SQ_W'(bb_hh_s5) << (2 * H_W)) + (SQ_W'(bb_hl_s5) << (H_W + 1))
				+ SQ_W'(bb_ll_s5);
			ac_s6   <= (SQ_W'(ac_hh_s5) << (2 * H_W))
				+ ((SQ_W'(ac_hl_s5) + SQ_W'(ac_lh_s5)) << H_W) + SQ_W'(ac_ll_s5);
			pre_s6  <= pre_s5;
			cneg_s6 <= cneg_s5;
			face_s6 <= face_s5;
			last_s6 <= last_s5;
		end
	end

	// Stage 7: discriminant sign, face sign and result bit.
	logic             disc_pos_w, hit_w;
	logic [IDX_W-1:0] bits_w;
	logic [TB_W-1:0]  tb_m1_w;

	assign disc_pos_w = !cneg_s6 || (CMP_W'(sq_s6) > (CMP_W'(ac_s6) << 2));
	assign hit_w      = (face_s6 == (pre_s6 && disc_pos_w));
	assign tb_m1_w    = test_bit - cit_pkg::TB_MIN;
	assign bits_w     = (hit_w && (test_bit >= cit_pkg::TB_MIN) && (test_bit <= cit_pkg::TB_MAX))
		? (IDX_W'(1) << tb_m1_w[SH_W-1:0]) : '0;

	logic [IDX_W-1:0] bits_s7;
	logic             last_s7;

	always_ff @(posedge clk) begin
		if (en7 && v_s6) begin
			bits_s7 <= bits_w;
			last_s7 <= last_s6;
		end
	end

	assign result.valid       = v_s7;
	assign result.index_bits  = bits_s7;
	assign result.last_result = last_s7;

endmodule
